// File: rtl/gsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg: shared types, constants and functions
// Constants for the GPS seconds to calendar converter, the step of the
// constant divider and the month lookup.
// ----------------------------------------------------------------------------
package gsc_pkg;

  // Field widths of the stream ports.
  localparam int unsigned IN_W     = 41;
  localparam int unsigned T_W      = 42;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned CFG_W    = 16;

  // Seconds from proleptic day zero to the GPS epoch.
  localparam logic [T_W-1:0] EPOCH_SECS = T_W'(64'd86400 * 64'd723185);

  // Seconds are split as t = 128 * u + low, then u is divided by 675.
  localparam int unsigned LOW_W      = 7;
  localparam int unsigned DIVU_W     = T_W - LOW_W;
  localparam int unsigned REM_W      = 10;
  localparam logic [REM_W-1:0] DIV_DEN = REM_W'(675);
  localparam int unsigned DIV_BITS   = 5;
  localparam int unsigned DIV_STAGES = DIVU_W / DIV_BITS;

  // Internal value widths.
  localparam int unsigned DAYS_W = 25;
  localparam int unsigned SOD_W  = REM_W + LOW_W;
  localparam int unsigned YR_W   = 17;
  localparam int unsigned DOY_W  = 9;

  // Year estimate: (days - 183) * 400 / 146097 by a reciprocal multiply.
  localparam logic [DAYS_W-1:0] EST_OFS = DAYS_W'(183);
  localparam int unsigned EST_SH = 32;
  localparam int unsigned MY_W   = 24;
  localparam logic [MY_W-1:0] MUL_Y = MY_W'((64'd400 << EST_SH) / 64'd146097);
  localparam int unsigned PY_W   = DAYS_W + MY_W;

  // Division by 100 of a 17-bit value.
  localparam int unsigned R100_SH = 24;
  localparam int unsigned R100_W  = 18;
  localparam logic [R100_W-1:0] MUL_100 =
    R100_W'(((64'd1 << R100_SH) + 64'd99) / 64'd100);
  localparam int unsigned P100_W  = YR_W + R100_W;
  localparam int unsigned Q100_W  = P100_W - R100_SH;

  // Division of the second of day by 3600 and of the remainder by 60.
  localparam int unsigned RH_SH = 32;
  localparam int unsigned RH_W  = 21;
  localparam logic [RH_W-1:0] MUL_H = RH_W'(((64'd1 << RH_SH) + 64'd3599) / 64'd3600);
  localparam int unsigned PH_W  = SOD_W + RH_W;
  localparam int unsigned RS_W  = 12;
  localparam int unsigned RM_SH = 20;
  localparam int unsigned RM_W  = 15;
  localparam logic [RM_W-1:0] MUL_M = RM_W'(((64'd1 << RM_SH) + 64'd59) / 64'd60);
  localparam int unsigned PM_W  = RS_W + RM_W;

  // Configuration register indexes.
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  // First day of each month in a common year.
  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIVU_W-1:0] num;
    logic [LOW_W-1:0]  low;
  } div_st_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } md_t;

  // Several bits of restoring division by 675; quotient bits shift into num.
  function automatic div_st_t div_step(input div_st_t a);
    div_st_t r;
    logic [REM_W:0] t;
    r = a;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r.rem, r.num[DIVU_W-1]};
      r.num = {r.num[DIVU_W-2:0], 1'b0};
      if (t >= {1'b0, DIV_DEN}) begin
        t = t - {1'b0, DIV_DEN};
        r.num[0] = 1'b1;
      end
      r.rem = t[REM_W-1:0];
    end
    return r;
  endfunction

  // Month and day of month from the zero-based day of year.
  function automatic md_t month_day(input logic [DOY_W-1:0] doy, input logic leap);
    md_t r;
    logic [DOY_W-1:0] s;
    r.month = 4'd1;
    r.day   = 5'(doy + 9'd1);
    for (int m = 1; m < 12; m++) begin
      s = MONTH_START[m] + ((leap && (m >= 2)) ? 9'd1 : 9'd0);
      if (doy >= s) begin
        r.month = 4'(m + 1);
        r.day   = 5'(doy - s + 9'd1);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/gsc_day_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_day_div: day number and second of day
// Adds the epoch offset and divides the seconds by 86400 in a pipeline of
// restoring division stages, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module gsc_day_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [gsc_pkg::IN_W-1:0]    secs_i,
  output logic                        valid_o,
  output logic [gsc_pkg::DAYS_W-1:0]  days_o,
  output logic [gsc_pkg::SOD_W-1:0]   sod_o
);
  import gsc_pkg::*;

  logic [DIV_STAGES:0] valid_q;
  div_st_t             st_q [DIV_STAGES+1];
  logic [T_W-1:0]      t_d;

  // Seconds since day zero.
  assign t_d = T_W'(secs_i) + EPOCH_SECS;

  // Valid bits travel with the beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[DIV_STAGES-1:0], valid_i};
    end
  end

  // First stage loads the dividend, then each stage retires DIV_BITS bits.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0] <= '{rem: '0, num: t_d[T_W-1:LOW_W], low: t_d[LOW_W-1:0]};
      for (int s = 1; s <= DIV_STAGES; s++) begin
        st_q[s] <= div_step(st_q[s-1]);
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES];
  assign days_o  = st_q[DIV_STAGES].num[DAYS_W-1:0];
  assign sod_o   = {st_q[DIV_STAGES].rem, st_q[DIV_STAGES].low};

endmodule

// File: rtl/gsc_tod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_tod: time of day
// Splits the second of day into hour, minute and second over four stages
// of reciprocal multiplies.
// ----------------------------------------------------------------------------
module gsc_tod (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  logic [gsc_pkg::SOD_W-1:0]  sod_i,
  output logic [4:0]                 hour_o,
  output logic [5:0]                 minute_o,
  output logic [5:0]                 second_o
);
  import gsc_pkg::*;

  logic [SOD_W-1:0] sod1_q;
  logic [PH_W-1:0]  hp_q;
  logic [4:0]       hour2_q, hour3_q, hour4_q;
  logic [RS_W-1:0]  rem2_q, rem3_q;
  logic [PM_W-1:0]  mp_q;
  logic [5:0]       min4_q, sec4_q;
  logic [4:0]       hour_d;
  logic [5:0]       min_d;

  assign hour_d = hp_q[RH_SH+4:RH_SH];
  assign min_d  = mp_q[RM_SH+5:RM_SH];

  // Hour product, hour and remainder, minute product, minute and second.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sod1_q  <= sod_i;
      hp_q    <= PH_W'(sod_i) * PH_W'(MUL_H);
      hour2_q <= hour_d;
      rem2_q  <= RS_W'(sod1_q - SOD_W'(hour_d) * SOD_W'(3600));
      hour3_q <= hour2_q;
      rem3_q  <= rem2_q;
      mp_q    <= PM_W'(rem2_q) * PM_W'(MUL_M);
      hour4_q <= hour3_q;
      min4_q  <= min_d;
      sec4_q  <= 6'(rem3_q - RS_W'(min_d) * RS_W'(60));
    end
  end

  assign hour_o   = hour4_q;
  assign minute_o = min4_q;
  assign second_o = sec4_q;

endmodule

// File: rtl/gsc_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_date: year and day of year
// Estimates the year from the day number, checks it against the first
// days of two candidate years and gives the year, day of year and leap flag.
// ----------------------------------------------------------------------------
module gsc_date (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [gsc_pkg::DAYS_W-1:0]  days_i,
  output logic                        valid_o,
  output logic [gsc_pkg::YR_W-1:0]    year_o,
  output logic [gsc_pkg::DOY_W-1:0]   doy_o,
  output logic                        leap_o
);
  import gsc_pkg::*;

  logic [3:0]        valid_q;
  logic [DAYS_W-1:0] days1_q, days2_q, days3_q;
  logic [PY_W-1:0]   py_q;
  logic [YR_W-1:0]   e2_q, e3_q;
  logic [P100_W-1:0] pa_q [2];
  logic [P100_W-1:0] pb_q [2];
  logic [DAYS_W-1:0] ys_q [2];
  logic [1:0]        leap3_q;
  logic [YR_W-1:0]   year4_q;
  logic [DOY_W-1:0]  doy4_q;
  logic              leap4_q;
  logic [YR_W-1:0]   e_d;
  logic [DAYS_W-1:0] ys_d [2];
  logic [1:0]        leap_d;
  logic              sel_d;

  assign e_d = py_q[EST_SH+YR_W-1:EST_SH];

  // First day and leap flag of candidate years e and e + 1.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic [YR_W-1:0]   c, a, b;
      logic [Q100_W-1:0] q1, q4;
      c = e2_q + YR_W'(k);
      a = c + YR_W'(99);
      b = c + YR_W'(399);
      q1 = pa_q[k][P100_W-1:R100_SH];
      q4 = pb_q[k][P100_W-1:R100_SH];
      ys_d[k] = DAYS_W'(c) * DAYS_W'(365) + DAYS_W'(YR_W'((c + YR_W'(3)) >> 2))
                - DAYS_W'(q1) + DAYS_W'(q4);
      leap_d[k] = (c[1:0] == 2'b00) &&
                  (((a - YR_W'(q1) * YR_W'(100)) != YR_W'(99)) ||
                   ((b - YR_W'(q4) * YR_W'(400)) == YR_W'(399)));
    end
  end

  assign sel_d = (days3_q >= ys_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Estimate, divisions by 100 and 400, first days, final selection.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      days1_q <= days_i;
      py_q    <= PY_W'(days_i - EST_OFS) * PY_W'(MUL_Y);
      days2_q <= days1_q;
      e2_q    <= e_d;
      for (int k = 0; k < 2; k++) begin
        pa_q[k] <= P100_W'(e_d + YR_W'(k) + YR_W'(99)) * P100_W'(MUL_100);
        pb_q[k] <= P100_W'((e_d + YR_W'(k) + YR_W'(399)) >> 2) * P100_W'(MUL_100);
        ys_q[k] <= ys_d[k];
      end
      days3_q <= days2_q;
      e3_q    <= e2_q;
      leap3_q <= leap_d;
      year4_q <= e3_q + YR_W'(sel_d);
      doy4_q  <= DOY_W'(days3_q - (sel_d ? ys_q[1] : ys_q[0]));
      leap4_q <= sel_d ? leap3_q[1] : leap3_q[0];
    end
  end

  assign valid_o = valid_q[3];
  assign year_o  = year4_q;
  assign doy_o   = doy4_q;
  assign leap_o  = leap4_q;

endmodule

// File: rtl/gps_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_seconds_to_calendar: GPS seconds to Gregorian date and time
// Converts seconds since the GPS epoch into year, month, day, hour, minute
// and second, and flags years inside the configured range.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one beat of GPS seconds in tdata[40:0]. The
//   master stream gives one beat per input: tdata carries year, month, day,
//   hour, minute and second; tuser is the valid flag, set when the year lies
//   between min_year and max_year (register 0 and 1 of the write port).
//   The block takes a beat every cycle unless the output is stalled:
//   eight stages divide by 86400, four stages find the year and the time
//   of day, and one output register finishes the date.
//   Reset empties the pipeline and sets the year range to 1980 to 2099.
//   When a finished beat waits and the receiver stalls, the whole pipeline
//   holds and s_axis_tready drops, so no beat is lost or repeated. Write
//   the range registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module gps_seconds_to_calendar (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // [40:0] gps_seconds
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] year, [19:16] month, [24:20] day, [29:25] hour, [35:30] minute,
  // [41:36] second
  output logic [47:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,  // [0] valid_res
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gsc_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import gsc_pkg::*;

  logic              adv;
  logic              dv_valid;
  logic [DAYS_W-1:0] dv_days;
  logic [SOD_W-1:0]  dv_sod;
  logic              dt_valid;
  logic [YR_W-1:0]   dt_year;
  logic [DOY_W-1:0]  dt_doy;
  logic              dt_leap;
  logic [4:0]        hour;
  logic [5:0]        minute, second;
  md_t               md;
  logic              in_range;
  logic [CFG_W-1:0]  min_q, max_q;
  logic              out_valid_q;
  logic [47:0]       out_data_q;
  logic              out_user_q;

  // The pipeline moves unless a finished beat waits at the output and the receiver is not ready.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Range registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= CFG_W'(1980);
      max_q <= CFG_W'(2099);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_YEAR: min_q <= cfg_wdata_i;
        CFG_MAX_YEAR: max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gsc_day_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid),
    .secs_i  (s_axis_tdata[IN_W-1:0]),
    .valid_o (dv_valid),
    .days_o  (dv_days),
    .sod_o   (dv_sod)
  );

  gsc_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_valid),
    .days_i  (dv_days),
    .valid_o (dt_valid),
    .year_o  (dt_year),
    .doy_o   (dt_doy),
    .leap_o  (dt_leap)
  );

  gsc_tod u_tod (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sod_i    (dv_sod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  // Month lookup and range check.
  assign md       = month_day(dt_doy, dt_leap);
  assign in_range = (YR_W'(min_q) <= dt_year) && (dt_year <= YR_W'(max_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dt_valid;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {6'd0, second, minute, hour, md.day, md.month,
                     dt_year[YEAR_W-1:0]};
      out_user_q <= in_range;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19:16] >= 4'd1) && (m_axis_tdata[19:16] <= 4'd12))
    else $error("month out of range");
  a_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24:20] != 5'd0))
    else $error("day of month is zero");
  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[29:25] < 5'd24) && (m_axis_tdata[35:30] < 6'd60)
                      && (m_axis_tdata[41:36] < 6'd60))
    else $error("time of day out of range");
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (min_q <= m_axis_tdata[15:0])
                                        && (m_axis_tdata[15:0] <= max_q))
    else $error("valid flag set for a year outside the range");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gps_seconds_to_calendar
// Drives GPS second counts through the stream input, predicts the calendar
// date and time of each beat and compares every output beat field by field.
// Runs several idling phases, a long receiver hold-off and year ranges.
// ----------------------------------------------------------------------------
module testbench;
  import gsc_pkg::*;

  localparam longint unsigned EPOCH_DAY  = 723185;
  localparam longint unsigned SEC_DAY    = 86400;
  localparam longint unsigned DAYS_400Y  = 146097;
  localparam longint unsigned TOP_SECS   = 64'h1FF_FFFF_FFFF;
  localparam int unsigned     LATENCY    = 13;
  localparam int unsigned     LIMIT      = 2000000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic        ok;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  typedef struct {
    longint unsigned secs;
    bit              known;
    date_t           want;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  // Local copy of the year range registers.
  logic [15:0] lo_year;
  logic [15:0] hi_year;

  date_t      pending_dates[$];
  idle_mode_e idle_mode;
  int         hold_cycles;
  int         errors;
  int unsigned cycle_count;

  gps_seconds_to_calendar dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint unsigned first_day(longint unsigned y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // Predicts the calendar date of a GPS second count under the current range.
  function automatic date_t gps_to_date(longint unsigned secs);
    date_t r;
    longint unsigned t, days, y, doy, len;
    bit leap;
    t = (secs & TOP_SECS) + SEC_DAY * EPOCH_DAY;
    r.second = 6'(t % 60);
    t = t / 60;
    r.minute = 6'(t % 60);
    t = t / 60;
    r.hour = 5'(t % 24);
    days = t / 24;
    y = (days > 365) ? ((days - 365) * 400 + 200) / DAYS_400Y : 0;
    for (int i = 0; i < 3; i++) if (y > 0 && first_day(y) > days) y--;
    for (int i = 0; i < 3; i++) if (first_day(y + 1) <= days) y++;
    doy = days - first_day(y);
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    r.month = 4'd12;
    r.day = 5'd1;
    for (int m = 0; m < 12; m++) begin
      if (m == 1) len = leap ? 29 : 28;
      else len = ((12'hAD5 >> m) & 1) ? 31 : 30;
      if (doy < len) begin
        r.month = 4'(m + 1);
        r.day = 5'(doy + 1);
        break;
      end
      doy -= len;
    end
    r.year = 16'(y);
    r.ok = (lo_year <= y) && (y <= hi_year);
    return r;
  endfunction

  // Receiver: stalls by phase, plus a long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= ((idle_mode == IDLE_RECV) ? 87 : 9));
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Checks each output beat against the oldest predicted date.
  always @(posedge clk_i) begin
    date_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{ok: m_axis_tuser, year: m_axis_tdata[15:0],
              month: m_axis_tdata[19:16], day: m_axis_tdata[24:20],
              hour: m_axis_tdata[29:25], minute: m_axis_tdata[35:30],
              second: m_axis_tdata[41:36]};
      if (pending_dates.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Presents one register write; the caller drops the write enable afterward.
  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == CFG_MIN_YEAR) lo_year = value;
    else hi_year = value;
  endtask

  // Waits for all predicted dates, then lets the pipeline settle.
  task automatic drain();
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Sends one beat and records its prediction when accepted.
  task automatic send_beat(longint unsigned secs, bit known, date_t want);
    date_t pred;
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 87 : 9)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, secs[40:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = gps_to_date(secs);
    if (known && pred !== want) begin
      errors++;
      if (errors <= 10) $display("prediction disagrees for %0d", secs);
    end
    pending_dates.push_back(pred);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Counts spread over the whole range, near its top, small ones and ones below 2^33.
  function automatic longint unsigned random_secs();
    longint unsigned v;
    case ($urandom_range(3))
      0: v = {$urandom(), $urandom()} & TOP_SECS;
      1: v = TOP_SECS - $urandom_range(100000000);
      2: v = $urandom_range(100000);
      default: v = {$urandom_range(1), $urandom()};
    endcase
    return v;
  endfunction

  vector_t directed[] = '{
    '{0,          1'b1, '{1'b1, 16'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 6'd0}},
    '{59,         1'b1, '{1'b1, 16'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 6'd59}},
    '{86399,      1'b1, '{1'b1, 16'd1980, 4'd1, 5'd6, 5'd23, 6'd59, 6'd59}},
    '{86400,      1'b1, '{1'b1, 16'd1980, 4'd1, 5'd7, 5'd0, 6'd0, 6'd0}},
    '{4665600,    1'b1, '{1'b1, 16'd1980, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}},
    '{31104000,   1'b1, '{1'b1, 16'd1980, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0}},
    '{31190400,   1'b1, '{1'b1, 16'd1981, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{TOP_SECS,   1'b0, '0},
    '{TOP_SECS-1, 1'b0, '0},
    '{64'h100_0000_0000, 1'b0, '0},
    '{64'h0AA_AAAA_AAAA, 1'b0, '0},
    '{64'h155_5555_5555, 1'b0, '0},
    '{630720000,  1'b0, '0},
    '{3786912000, 1'b0, '0},
    '{3818534399, 1'b0, '0},
    '{3818534400, 1'b0, '0},
    '{12600000000, 1'b0, '0},
    '{638553600,  1'b0, '0}
  };

  initial begin
    idle_mode = IDLE_NONE;
    hold_cycles = 0;
    errors = 0;
    cycle_count = 0;
    lo_year = 16'd1980;
    hi_year = 16'd2099;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MIN_YEAR;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table with the reset range.
    foreach (directed[i]) send_beat(directed[i].secs, directed[i].known, directed[i].want);
    end_burst();
    drain();

    // Random phases, each with its own idling and year range.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MIN_YEAR, 16'd0);    write_reg(CFG_MAX_YEAR, 16'hFFFF); end
        1: begin write_reg(CFG_MIN_YEAR, 16'd2000); write_reg(CFG_MAX_YEAR, 16'd2050); end
        2: begin write_reg(CFG_MIN_YEAR, 16'hFFFF); write_reg(CFG_MAX_YEAR, 16'd0);    end
        3: begin write_reg(CFG_MIN_YEAR, 16'd2024); write_reg(CFG_MAX_YEAR, 16'd2024); end
        4: begin write_reg(CFG_MIN_YEAR, 16'hAAAA); write_reg(CFG_MAX_YEAR, 16'h5555); end
        default: begin
          write_reg(CFG_MIN_YEAR, 16'h5555); write_reg(CFG_MAX_YEAR, 16'hFFFE);
        end
      endcase
      cfg_we_i <= 1'b0;
      idle_mode = idle_mode_e'(ph % 4);
      // Long receiver hold-off while the sender keeps offering beats.
      if (ph == 1) hold_cycles = 300;
      for (int n = 0; n < 240; n++) begin
        send_beat(random_secs(), 1'b0, '0);
        if (idle_mode == IDLE_NONE && $urandom_range(49) == 0) end_burst();
      end
      end_burst();
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
